[rtl/vertex_angle_cosine_top_macros.svh]
// Assertion helpers shared by the RTL. Clock and reset names are fixed to
// the house convention (clk_i, rst_ni).
`ifndef VERTEX_ANGLE_COSINE_TOP_MACROS_SVH
`define VERTEX_ANGLE_COSINE_TOP_MACROS_SVH

// Same-cycle implication.
`define VAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/vac_pkg.sv]
package vac_pkg;

  // Result width, Q2.14 at the default fraction size.
  localparam int COS_W = 16;

  // Squared length / dot magnitude width.
  function automatic int len_w(int cb);
    return 2 * cb + 1;
  endfunction

  // Width of L1*L2 and dot^2.
  function automatic int prod_w(int cb);
    return 4 * cb + 2;
  endfunction

  // Width of the root residual and its running terms.
  function automatic int res_w(int cb, int fb);
    return 4 * cb + 2 + 2 * fb + 3;
  endfunction

endpackage

[rtl/vac_front.sv]
module vac_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic signed [COORD_BITS-1:0]       ax_i,
  input  logic signed [COORD_BITS-1:0]       ay_i,
  input  logic signed [COORD_BITS-1:0]       vx_i,
  input  logic signed [COORD_BITS-1:0]       vy_i,
  input  logic signed [COORD_BITS-1:0]       bx_i,
  input  logic signed [COORD_BITS-1:0]       by_coord_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output logic [vac_pkg::len_w(COORD_BITS)-1:0] l1_o,
  output logic [vac_pkg::len_w(COORD_BITS)-1:0] l2_o,
  output logic [vac_pkg::len_w(COORD_BITS)-1:0] dmag_o,
  output logic                               neg_o,
  output logic                               dg_o
);

  localparam int DW  = COORD_BITS + 1;
  localparam int SW  = 2 * COORD_BITS;
  localparam int LW  = vac_pkg::len_w(COORD_BITS);
  localparam int MSB = COORD_BITS - 1;

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  // stage 1: difference vectors
  logic signed [DW-1:0] ux_d, uy_d, wx_d, wy_d;
  logic signed [DW-1:0] ux_q, uy_q, wx_q, wy_q;
  // stage 2: products
  logic signed [2*DW-1:0] uxx, uyy, wxx, wyy, pxw, pyw;
  logic [SW-1:0]          uxx_q, uyy_q, wxx_q, wyy_q;
  logic signed [SW:0]     pxw_q, pyw_q;
  // stage 3: sums
  logic [LW-1:0]          l1_d, l2_d, dmag_d;
  logic signed [SW+1:0]   dot;
  logic [SW+1:0]          dot_abs;
  logic [LW-1:0]          l1_q, l2_q, dmag_q;
  logic                   neg_q, dg_q;

  assign en3     = ~v3_q | ready_i;
  assign en2     = ~v2_q | en3;
  assign en1     = ~v1_q | en2;
  assign ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_comb begin
    ux_d = $signed({ax_i[MSB], ax_i}) - $signed({vx_i[MSB], vx_i});
    uy_d = $signed({ay_i[MSB], ay_i}) - $signed({vy_i[MSB], vy_i});
    wx_d = $signed({bx_i[MSB], bx_i}) - $signed({vx_i[MSB], vx_i});
    wy_d = $signed({by_coord_i[MSB], by_coord_i}) - $signed({vy_i[MSB], vy_i});
  end

  assign uxx = ux_q * ux_q;
  assign uyy = uy_q * uy_q;
  assign wxx = wx_q * wx_q;
  assign wyy = wy_q * wy_q;
  assign pxw = ux_q * wx_q;
  assign pyw = uy_q * wy_q;

  always_comb begin
    l1_d    = {1'b0, uxx_q} + {1'b0, uyy_q};
    l2_d    = {1'b0, wxx_q} + {1'b0, wyy_q};
    dot     = $signed({pxw_q[SW], pxw_q}) + $signed({pyw_q[SW], pyw_q});
    dot_abs = dot[SW+1] ? (~dot + 1'b1) : dot;
    dmag_d  = dot_abs[LW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ux_q <= ux_d;
      uy_q <= uy_d;
      wx_q <= wx_d;
      wy_q <= wy_d;
    end
    if (en2) begin
      // squares are never negative and stay below 2^SW
      uxx_q <= uxx[SW-1:0];
      uyy_q <= uyy[SW-1:0];
      wxx_q <= wxx[SW-1:0];
      wyy_q <= wyy[SW-1:0];
      pxw_q <= pxw[SW:0];
      pyw_q <= pyw[SW:0];
    end
    if (en3) begin
      l1_q   <= l1_d;
      l2_q   <= l2_d;
      dmag_q <= dmag_d;
      neg_q  <= dot[SW+1];
      dg_q   <= (l1_d == '0) | (l2_d == '0);
    end
  end

  assign valid_o = v3_q;
  assign l1_o    = l1_q;
  assign l2_o    = l2_q;
  assign dmag_o  = dmag_q;
  assign neg_o   = neg_q;
  assign dg_o    = dg_q;

endmodule

[rtl/vac_sqmul.sv]
module vac_sqmul #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          valid_i,
  output logic                                          ready_o,
  input  logic [vac_pkg::len_w(COORD_BITS)-1:0]         l1_i,
  input  logic [vac_pkg::len_w(COORD_BITS)-1:0]         l2_i,
  input  logic [vac_pkg::len_w(COORD_BITS)-1:0]         dmag_i,
  input  logic                                          neg_i,
  input  logic                                          dg_i,
  output logic                                          valid_o,
  input  logic                                          ready_i,
  output logic [vac_pkg::prod_w(COORD_BITS)-1:0]        p_o,
  output logic [vac_pkg::res_w(COORD_BITS, FRAC_BITS)-1:0] e_o,
  output logic                                          neg_o,
  output logic                                          dg_o
);

  localparam int LW = vac_pkg::len_w(COORD_BITS);
  localparam int PW = vac_pkg::prod_w(COORD_BITS);
  localparam int RW = vac_pkg::res_w(COORD_BITS, FRAC_BITS);
  localparam int H  = COORD_BITS + 1;   // low half
  localparam int HB = LW - H;           // high half

  logic v1_q, v2_q;
  logic en1, en2;

  logic [H-1:0]  a_lo, b_lo, d_lo;
  logic [HB-1:0] a_hi, b_hi, d_hi;

  // partial products, each at most (COORD_BITS+1) x (COORD_BITS+1) bits
  logic [2*H-1:0]   pll_q, dll_q;
  logic [H+HB-1:0]  plh_q, phl_q, dlh_q;
  logic [2*HB-1:0]  phh_q, dhh_q;
  logic             neg1_q, dg1_q;

  logic [PW-1:0] p_d, d2_d;
  logic [PW-1:0] p_q;
  logic [RW-1:0] e_q;
  logic          neg2_q, dg2_q;

  assign en2     = ~v2_q | ready_i;
  assign en1     = ~v1_q | en2;
  assign ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  assign a_lo = l1_i[H-1:0];
  assign a_hi = l1_i[LW-1:H];
  assign b_lo = l2_i[H-1:0];
  assign b_hi = l2_i[LW-1:H];
  assign d_lo = dmag_i[H-1:0];
  assign d_hi = dmag_i[LW-1:H];

  always_comb begin
    p_d  = (PW'(phh_q) << (2 * H)) + (PW'(phl_q) << H) + (PW'(plh_q) << H) + PW'(pll_q);
    // cross term appears twice in a square
    d2_d = (PW'(dhh_q) << (2 * H)) + (PW'(dlh_q) << (H + 1)) + PW'(dll_q);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      pll_q  <= (2*H)'(a_lo) * (2*H)'(b_lo);
      plh_q  <= (H+HB)'(a_lo) * (H+HB)'(b_hi);
      phl_q  <= (H+HB)'(a_hi) * (H+HB)'(b_lo);
      phh_q  <= (2*HB)'(a_hi) * (2*HB)'(b_hi);
      dll_q  <= (2*H)'(d_lo) * (2*H)'(d_lo);
      dlh_q  <= (H+HB)'(d_lo) * (H+HB)'(d_hi);
      dhh_q  <= (2*HB)'(d_hi) * (2*HB)'(d_hi);
      neg1_q <= neg_i;
      dg1_q  <= dg_i;
    end
    if (en2) begin
      p_q    <= p_d;
      e_q    <= RW'(d2_d) << (2 * FRAC_BITS);
      neg2_q <= neg1_q;
      dg2_q  <= dg1_q;
    end
  end

  assign valid_o = v2_q;
  assign p_o     = p_q;
  assign e_o     = e_q;
  assign neg_o   = neg2_q;
  assign dg_o    = dg2_q;

endmodule

[rtl/vac_root_stage.sv]
`include "vertex_angle_cosine_top_macros.svh"

// One bit of the restoring root search: try n | 2^BIT against residual
// E = 2^(2F)*D^2 - n^2*P, with Q = n*P kept alongside.
module vac_root_stage #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 14,
  parameter int BIT        = 14
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             valid_i,
  output logic                                             ready_o,
  input  logic [vac_pkg::prod_w(COORD_BITS)-1:0]           p_i,
  input  logic [vac_pkg::res_w(COORD_BITS, FRAC_BITS)-1:0] e_i,
  input  logic [vac_pkg::res_w(COORD_BITS, FRAC_BITS)-1:0] q_i,
  input  logic [FRAC_BITS:0]                               n_i,
  input  logic                                             neg_i,
  input  logic                                             dg_i,
  output logic                                             valid_o,
  input  logic                                             ready_i,
  output logic [vac_pkg::prod_w(COORD_BITS)-1:0]           p_o,
  output logic [vac_pkg::res_w(COORD_BITS, FRAC_BITS)-1:0] e_o,
  output logic [vac_pkg::res_w(COORD_BITS, FRAC_BITS)-1:0] q_o,
  output logic [FRAC_BITS:0]                               n_o,
  output logic                                             neg_o,
  output logic                                             dg_o
);

  localparam int PW = vac_pkg::prod_w(COORD_BITS);
  localparam int RW = vac_pkg::res_w(COORD_BITS, FRAC_BITS);
  localparam int NW = FRAC_BITS + 1;
  localparam logic [NW-1:0] BIT_MASK = NW'(1) << BIT;
  localparam logic [NW-1:0] LOW_MASK = BIT_MASK - NW'(1);
  localparam logic [NW-1:0] ONE      = NW'(1) << FRAC_BITS;

  logic          v_q, en;
  logic [RW-1:0] p_ext, t, q_d, e_d;
  logic [RW:0]   diff;
  logic          take;
  logic [NW-1:0] n_d;

  logic [PW-1:0] p_q;
  logic [RW-1:0] e_q, q_q;
  logic [NW-1:0] n_q;
  logic          neg_q, dg_q;

  assign en      = ~v_q | ready_i;
  assign ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  // (n + 2^b)^2 P - n^2 P = 2^(b+1) Q + 2^(2b) P
  always_comb begin
    p_ext = RW'(p_i);
    t     = (q_i << (BIT + 1)) + (p_ext << (2 * BIT));
    diff  = {1'b0, e_i} - {1'b0, t};
    take  = ~diff[RW];
    e_d   = take ? diff[RW-1:0] : e_i;
    q_d   = take ? (q_i + (p_ext << BIT)) : q_i;
    n_d   = take ? (n_i | BIT_MASK) : n_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q   <= p_i;
      e_q   <= e_d;
      q_q   <= q_d;
      n_q   <= n_d;
      neg_q <= neg_i;
      dg_q  <= dg_i;
    end
  end

  assign valid_o = v_q;
  assign p_o     = p_q;
  assign e_o     = e_q;
  assign q_o     = q_q;
  assign n_o     = n_q;
  assign neg_o   = neg_q;
  assign dg_o    = dg_q;

  `VAC_ASSERT_NOW(a_low_bits_clear, v_q, (n_q & LOW_MASK) == '0, "root bits below stage set")
  `VAC_ASSERT_NOW(a_root_range, v_q && !dg_q, n_q <= ONE, "root above one")
  `VAC_ASSERT_NOW(a_full_residual, v_q && !dg_q && (n_q == ONE), e_q == '0,
                  "aligned vectors left residual")

endmodule

[rtl/vertex_angle_cosine_top.sv]
// Cosine of the angle at vertex V between A-V and B-V.
//
// Input channel (in_valid_i / in_ready_o): six signed COORD_BITS-wide
// coordinates ax, ay, vx, vy, bx, by_coord, one point triple per transfer.
// Output channel (out_valid_o / out_ready_i): cosine_o in signed fixed point
// with FRAC_BITS fraction bits (Q2.14 by default), truncated toward zero and
// kept to 16 bits; degenerate_o flags a zero-length vector, cosine_o is then 0.
//
// Throughput: one transfer per cycle on each side while the receiver keeps
// out_ready_i high. Pipeline: 3 front stages (differences, products, sums),
// 2 stages for the split L1*L2 and dot^2 multiplies, one stage per result
// bit of the root search (FRAC_BITS + 1), and the output register.
//
// Reset clears all valid bits; the pipeline comes out empty. When the
// receiver stalls, each stage holds if the one after it is full, so bubbles
// are squeezed out and new transfers are still taken until every stage holds
// an item.
`include "vertex_angle_cosine_top_macros.svh"

module vertex_angle_cosine_top #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COORD_BITS-1:0]        ax_i,
  input  logic signed [COORD_BITS-1:0]        ay_i,
  input  logic signed [COORD_BITS-1:0]        vx_i,
  input  logic signed [COORD_BITS-1:0]        vy_i,
  input  logic signed [COORD_BITS-1:0]        bx_i,
  input  logic signed [COORD_BITS-1:0]        by_coord_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [vac_pkg::COS_W-1:0]    cosine_o,
  output logic                                degenerate_o
);

  localparam int LW    = vac_pkg::len_w(COORD_BITS);
  localparam int PW    = vac_pkg::prod_w(COORD_BITS);
  localparam int RW    = vac_pkg::res_w(COORD_BITS, FRAC_BITS);
  localparam int NW    = FRAC_BITS + 1;
  localparam int COS_W = vac_pkg::COS_W;
  // room for the negated root before cutting to the result width
  localparam int OW    = (NW + 1 > COS_W) ? NW + 1 : COS_W;

  // front -> multiplier
  logic          f_valid, f_ready, f_neg, f_dg;
  logic [LW-1:0] f_l1, f_l2, f_dmag;

  // root chain: index k feeds the stage for bit FRAC_BITS-k
  logic [PW-1:0] p_s   [FRAC_BITS+1];
  logic [RW-1:0] e_s   [FRAC_BITS+1];
  logic [RW-1:0] q_s   [FRAC_BITS+1];
  logic [NW-1:0] n_s   [FRAC_BITS+2];
  logic          neg_s [FRAC_BITS+2];
  logic          dg_s  [FRAC_BITS+2];
  logic          v_s   [FRAC_BITS+2];
  logic          r_s   [FRAC_BITS+2];

  // output register
  logic             out_v_q, out_en;
  logic [OW-1:0]    n_ext, n_sgn;
  logic [COS_W-1:0] cos_d, cos_q;
  logic             dg_q;

  vac_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .ready_o    (in_ready_o),
    .ax_i       (ax_i),
    .ay_i       (ay_i),
    .vx_i       (vx_i),
    .vy_i       (vy_i),
    .bx_i       (bx_i),
    .by_coord_i (by_coord_i),
    .valid_o    (f_valid),
    .ready_i    (f_ready),
    .l1_o       (f_l1),
    .l2_o       (f_l2),
    .dmag_o     (f_dmag),
    .neg_o      (f_neg),
    .dg_o       (f_dg)
  );

  vac_sqmul #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_sqmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .ready_o (f_ready),
    .l1_i    (f_l1),
    .l2_i    (f_l2),
    .dmag_i  (f_dmag),
    .neg_i   (f_neg),
    .dg_i    (f_dg),
    .valid_o (v_s[0]),
    .ready_i (r_s[0]),
    .p_o     (p_s[0]),
    .e_o     (e_s[0]),
    .neg_o   (neg_s[0]),
    .dg_o    (dg_s[0])
  );

  // search starts from n = 0, so Q = n*P = 0
  assign q_s[0] = '0;
  assign n_s[0] = '0;

  for (genvar k = 0; k <= FRAC_BITS; k++) begin : g_root
    if (k < FRAC_BITS) begin : g_mid
      vac_root_stage #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .BIT        (FRAC_BITS - k)
      ) u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .valid_i (v_s[k]),
        .ready_o (r_s[k]),
        .p_i     (p_s[k]),
        .e_i     (e_s[k]),
        .q_i     (q_s[k]),
        .n_i     (n_s[k]),
        .neg_i   (neg_s[k]),
        .dg_i    (dg_s[k]),
        .valid_o (v_s[k+1]),
        .ready_i (r_s[k+1]),
        .p_o     (p_s[k+1]),
        .e_o     (e_s[k+1]),
        .q_o     (q_s[k+1]),
        .n_o     (n_s[k+1]),
        .neg_o   (neg_s[k+1]),
        .dg_o    (dg_s[k+1])
      );
    end else begin : g_last
      // residual and running product are not needed past bit 0
      vac_root_stage #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .BIT        (0)
      ) u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .valid_i (v_s[k]),
        .ready_o (r_s[k]),
        .p_i     (p_s[k]),
        .e_i     (e_s[k]),
        .q_i     (q_s[k]),
        .n_i     (n_s[k]),
        .neg_i   (neg_s[k]),
        .dg_i    (dg_s[k]),
        .valid_o (v_s[k+1]),
        .ready_i (r_s[k+1]),
        .p_o     (),
        .e_o     (),
        .q_o     (),
        .n_o     (n_s[k+1]),
        .neg_o   (neg_s[k+1]),
        .dg_o    (dg_s[k+1])
      );
    end
  end

  // Output stage: apply sign of the dot product, force 0 for a zero-length
  // vector (the root search runs wild there since P = 0).
  assign out_en          = ~out_v_q | out_ready_i;
  assign r_s[FRAC_BITS+1] = out_en;

  always_comb begin
    n_ext = OW'(n_s[FRAC_BITS+1]);
    n_sgn = neg_s[FRAC_BITS+1] ? (~n_ext + OW'(1)) : n_ext;
    cos_d = dg_s[FRAC_BITS+1] ? '0 : n_sgn[COS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= v_s[FRAC_BITS+1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      cos_q <= cos_d;
      dg_q  <= dg_s[FRAC_BITS+1];
    end
  end

  assign out_valid_o  = out_v_q;
  assign cosine_o     = $signed(cos_q);
  assign degenerate_o = dg_q;

  `VAC_ASSERT_NOW(a_degen_zero, out_valid_o && degenerate_o, cosine_o == '0,
                  "degenerate result with nonzero cosine")
  `VAC_ASSERT_NOW(a_full_when_blocked, !in_ready_o, out_valid_o && !out_ready_i,
                  "input blocked while output not stalled")
  `VAC_ASSERT_NEXT(a_blocked_holds, !in_ready_o && !out_ready_i, !in_ready_o || out_ready_i,
                   "input unblocked without an output transfer")

endmodule

[sim/vertex_angle_cosine_checker.sv]
module vertex_angle_cosine_checker #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic signed [COORD_BITS-1:0]        ax_i,
  input  logic signed [COORD_BITS-1:0]        ay_i,
  input  logic signed [COORD_BITS-1:0]        vx_i,
  input  logic signed [COORD_BITS-1:0]        vy_i,
  input  logic signed [COORD_BITS-1:0]        bx_i,
  input  logic signed [COORD_BITS-1:0]        by_coord_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [vac_pkg::COS_W-1:0]    cosine_i,
  input  logic                                degenerate_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  checked_o,
  output int                                  degen_seen_o
);

  localparam int COS_W = vac_pkg::COS_W;

  // wide enough for cand^2 * L1 * L2 and dot^2 << 2*FRAC_BITS
  localparam int WIDE_W = 4 * COORD_BITS + 2 * FRAC_BITS + 8;
  localparam int LEN_W  = 2 * COORD_BITS + 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t                  ax, ay, vx, vy, bx, by;
    logic signed [COS_W-1:0] cosine;
    logic                    degenerate;
  } cos_expect_t;

  cos_expect_t cos_expect_q[$];
  int          fail_cnt  = 0;
  int          check_cnt = 0;
  int          degen_cnt = 0;

  assign fail_count_o = fail_cnt;
  assign pending_o    = cos_expect_q.size();
  assign checked_o    = check_cnt;
  assign degen_seen_o = degen_cnt;

  // Exact integer cosine: largest n with n^2*L1*L2 <= 2^(2F)*dot^2, signed by dot.
  function automatic cos_expect_t predict_cosine(input coord_t pax, pay, pvx, pvy, pbx, pby);
    logic signed [COORD_BITS:0] ux, uy, wx, wy;
    logic signed [LEN_W-1:0]    dot, len_u, len_w;
    logic [LEN_W-1:0]           dot_mag;
    logic [WIDE_W-1:0]          len_prod, dot_scaled, trial;
    logic [FRAC_BITS+1:0]       root, cand;
    cos_expect_t                r;
    r.ax = pax; r.ay = pay; r.vx = pvx; r.vy = pvy; r.bx = pbx; r.by = pby;
    ux = pax - pvx;
    uy = pay - pvy;
    wx = pbx - pvx;
    wy = pby - pvy;
    dot   = ux * wx + uy * wy;
    len_u = ux * ux + uy * uy;
    len_w = wx * wx + wy * wy;
    if (len_u == 0 || len_w == 0) begin
      r.cosine     = '0;
      r.degenerate = 1'b1;
      return r;
    end
    dot_mag    = (dot < 0) ? -dot : dot;
    len_prod   = WIDE_W'(len_u) * WIDE_W'(len_w);
    dot_scaled = (WIDE_W'(dot_mag) * WIDE_W'(dot_mag)) << (2 * FRAC_BITS);
    root = '0;
    for (int b = FRAC_BITS; b >= 0; b--) begin
      cand = root | ((FRAC_BITS + 2)'(1) << b);
      if (cand <= ((FRAC_BITS + 2)'(1) << FRAC_BITS)) begin
        trial = WIDE_W'(cand) * WIDE_W'(cand) * len_prod;
        if (trial <= dot_scaled)
          root = cand;
      end
    end
    r.cosine     = (dot < 0) ? -COS_W'(root) : COS_W'(root);
    r.degenerate = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    fail_cnt++;
  endtask

  always @(posedge clk_i) begin
    cos_expect_t exp_r;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        cos_expect_q.push_back(predict_cosine(ax_i, ay_i, vx_i, vy_i, bx_i, by_coord_i));
      if (out_valid_i && out_ready_i) begin
        if (cos_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result cosine=%0d degenerate=%0b",
                                    cosine_i, degenerate_i));
        end else begin
          exp_r = cos_expect_q.pop_front();
          check_cnt++;
          if (exp_r.degenerate)
            degen_cnt++;
          if (cosine_i !== exp_r.cosine)
            report_mismatch($sformatf(
              "cosine got %0d exp %0d for A(%0d,%0d) V(%0d,%0d) B(%0d,%0d)",
              cosine_i, exp_r.cosine, exp_r.ax, exp_r.ay, exp_r.vx, exp_r.vy,
              exp_r.bx, exp_r.by));
          if (degenerate_i !== exp_r.degenerate)
            report_mismatch($sformatf(
              "degenerate got %0b exp %0b for A(%0d,%0d) V(%0d,%0d) B(%0d,%0d)",
              degenerate_i, exp_r.degenerate, exp_r.ax, exp_r.ay, exp_r.vx, exp_r.vy,
              exp_r.bx, exp_r.by));
        end
      end
    end
  end

endmodule

[sim/tb_vertex_angle_cosine_top.sv]
// Top of the cosine bench: builds stimulus, drives both handshakes and
// gives the verdict. All prediction and checking lives in the checker.
module tb_vertex_angle_cosine_top;

  localparam int COS_W      = vac_pkg::COS_W;
  localparam int CB         = 16;
  localparam int FB         = 14;
  localparam int LATENCY    = FB + 7;   // pipeline depth of the block
  localparam int RAND_ITEMS = 1030;
  localparam int IDLE_LIMIT = 2000;     // cycles without any transfer

  typedef logic signed [CB-1:0] coord_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t ax = '0, ay = '0, vx = '0, vy = '0, bx = '0, by_c = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  logic signed [COS_W-1:0] cosine;
  logic   degenerate;

  int fail_count, pending, checked, degen_seen;
  int sent       = 0;
  int calm_left  = 0;   // items left in a stretch with no input gaps
  int ready_hold = 0;   // cycles left in the current out_ready level
  int idle_cycles = 0;

  always #5 clk = ~clk;

  vertex_angle_cosine_top #(
    .COORD_BITS(CB),
    .FRAC_BITS (FB)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .ax_i        (ax),
    .ay_i        (ay),
    .vx_i        (vx),
    .vy_i        (vy),
    .bx_i        (bx),
    .by_coord_i  (by_c),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .cosine_o    (cosine),
    .degenerate_o(degenerate)
  );

  vertex_angle_cosine_checker #(
    .COORD_BITS(CB),
    .FRAC_BITS (FB)
  ) u_cos_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .ax_i        (ax),
    .ay_i        (ay),
    .vx_i        (vx),
    .vy_i        (vy),
    .bx_i        (bx),
    .by_coord_i  (by_c),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .cosine_i    (cosine),
    .degenerate_i(degenerate),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked),
    .degen_seen_o(degen_seen)
  );

  // Gap / stall length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Coordinate values at the edges of the range and alternating bit patterns.
  function automatic coord_t pick_edge();
    case ($urandom_range(0, 7))
      0: return coord_t'(-32768);
      1: return coord_t'(-32767);
      2: return coord_t'(-1);
      3: return coord_t'(0);
      4: return coord_t'(1);
      5: return coord_t'(32767);
      6: return coord_t'(16'h5555);
      default: return coord_t'(16'hAAAA);
    endcase
  endfunction

  // One transfer on the input channel, then an optional gap. Valid stays up
  // across back-to-back transfers, so it is only lowered when a gap follows.
  task automatic push_triple(input coord_t pax, pay, pvx, pvy, pbx, pby);
    int gap;
    ax   <= pax;
    ay   <= pay;
    vx   <= pvx;
    vy   <= pvy;
    bx   <= pbx;
    by_c <= pby;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (calm_left > 0)
      calm_left--;
    else if ($urandom_range(0, 59) == 0)
      calm_left = $urandom_range(30, 120);
    gap = (calm_left > 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random point triple; the mix leans toward cases that exercise the root
  // search edges: exact alignment, zero-length vectors, extreme coordinates.
  task automatic push_random();
    coord_t pax, pay, pvx, pvy, pbx, pby;
    int     r, ux, uy, k1, k2, ox, oy;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      pax = coord_t'($urandom); pay = coord_t'($urandom);
      pvx = coord_t'($urandom); pvy = coord_t'($urandom);
      pbx = coord_t'($urandom); pby = coord_t'($urandom);
    end else if (r < 70) begin
      // tiny vectors around a random vertex: frequent degenerate and exact cases
      ox  = $urandom_range(0, 60000) - 30000;
      oy  = $urandom_range(0, 60000) - 30000;
      pvx = coord_t'(ox); pvy = coord_t'(oy);
      pax = coord_t'(ox + $urandom_range(0, 8) - 4);
      pay = coord_t'(oy + $urandom_range(0, 8) - 4);
      pbx = coord_t'(ox + $urandom_range(0, 8) - 4);
      pby = coord_t'(oy + $urandom_range(0, 8) - 4);
    end else if (r < 82) begin
      // both vectors on one line, same or opposite direction
      ox = $urandom_range(0, 2000) - 1000;
      oy = $urandom_range(0, 2000) - 1000;
      ux = $urandom_range(0, 2000) - 1000;
      uy = $urandom_range(0, 2000) - 1000;
      k1 = $urandom_range(1, 30);
      k2 = $urandom_range(0, 60) - 30;
      pvx = coord_t'(ox); pvy = coord_t'(oy);
      pax = coord_t'(ox + k1 * ux); pay = coord_t'(oy + k1 * uy);
      pbx = coord_t'(ox + k2 * ux); pby = coord_t'(oy + k2 * uy);
    end else if (r < 94) begin
      pax = pick_edge(); pay = pick_edge();
      pvx = pick_edge(); pvy = pick_edge();
      pbx = pick_edge(); pby = pick_edge();
    end else begin
      // one endpoint sits on the vertex
      pvx = coord_t'($urandom); pvy = coord_t'($urandom);
      pax = coord_t'($urandom); pay = coord_t'($urandom);
      pbx = coord_t'($urandom); pby = coord_t'($urandom);
      if ($urandom_range(0, 1)) begin
        pax = pvx; pay = pvy;
      end else begin
        pbx = pvx; pby = pvy;
      end
    end
    push_triple(pax, pay, pvx, pvy, pbx, pby);
  endtask

  // Receiver: alternates ready and stalled stretches; occasionally a long
  // fully-ready stretch so the pipeline also runs at full rate.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!out_ready) begin
      out_ready  <= 1'b1;
      ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(80, 300)
                                                : $urandom_range(0, 12);
    end else begin
      out_ready  <= 1'b0;
      ready_hold <= pick_gap();
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results pending", IDLE_LIMIT,
               pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero-length vectors
    push_triple(0, 0, 0, 0, 0, 0);
    push_triple(5, -7, 5, -7, 100, 3);
    push_triple(-20, 9, 1, 1, 1, 1);
    push_triple(-1, -1, -1, -1, -1, -1);
    push_triple(-32768, -32768, -32768, -32768, -32768, -32768);
    // exact alignment, small and full-range, both signs
    push_triple(3, 4, 0, 0, 6, 8);
    push_triple(3, 4, 0, 0, -6, -8);
    push_triple(32767, 32767, -32768, -32768, 32767, 32767);
    push_triple(32767, 32767, 0, 0, -32768, -32768);
    // right angle: zero cosine but not degenerate
    push_triple(1, 0, 0, 0, 0, 1);
    push_triple(32766, 32767, 32767, 32767, 32767, 32766);
    // near +1 / -1 with the longest vectors
    push_triple(32767, 0, -32768, 0, 32767, 1);
    push_triple(32767, 0, 0, 0, -32768, 1);
    // everyday angles and 45 degree cases
    push_triple(1000, 0, 0, 0, 500, 866);
    push_triple(1000, 0, 0, 0, -500, 866);
    push_triple(32766, 32766, 32767, 32767, 32767, 32766);
    push_triple(1, 0, 0, 0, -1, 1);
    push_triple(7, 1, 0, 0, 1, 7);
    // corner mixes of the extreme coordinates
    push_triple(32767, -32768, -32768, 32767, -32768, -32768);
    push_triple(-32768, 32767, 32767, -32768, 32767, 32767);
    push_triple(-32768, -32768, 32767, 32767, -32768, 32767);
    push_triple(21845, -21846, -21846, 21845, 21845, 21845);

    repeat (RAND_ITEMS) push_random();
    in_valid <= 1'b0;
    // let the checker log the last transfer before polling its queue
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("Sent %0d point triples; %0d results checked, %0d of them degenerate.",
             sent, checked, degen_seen);
    $display("Covered range edges, exact alignment, zero-length vectors and random stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
